### rtl/espl_pkg.sv
// ----------------------------------------------------------------------------
// espl_pkg
// Shared types and constants for the encoder speed PID loop: field widths,
// register map, reset values, datapath operations and controller states.
// ----------------------------------------------------------------------------
package espl_pkg;

	localparam int PPR_W   = 16;
	localparam int SPEED_W = 24;
	localparam int DUTY_W  = 17;
	localparam int GAIN_W  = 32;
	localparam int SI_W    = 16;
	localparam int ERR_W   = 25;
	localparam int DIFF_W  = 26;
	localparam int INTEG_W = 41;
	localparam int ACC_W   = 63;
	localparam int PROD_W  = 64;
	localparam int NUM_W   = 38;
	localparam int CNT_W   = 6;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 3;

	// 60 s * 1e6 us * 10 * 256 (Q16.8)
	localparam logic [NUM_W-1:0]   SPEED_NUM = 38'd153600000000;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
	localparam logic [CNT_W-1:0]   DEN_LAST  = CNT_W'(PPR_W - 1);
	localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(NUM_W - 1);

	// gain terms are saturated at 2^60; the duty is sum >> 24 with full at 2^40
	localparam int TERM_SHIFT = 60;
	localparam int DUTY_SHIFT = 24;
	localparam int FULL_SHIFT = 40;
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << SI_W;

	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

	localparam logic [IDX_W-1:0] REG_KP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_KI  = 3'd1;
	localparam logic [IDX_W-1:0] REG_KD  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SI  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PPR = 3'd4;

	localparam logic [GAIN_W-1:0] KP_RST  = 32'd21474836;
	localparam logic [GAIN_W-1:0] KI_RST  = 32'd10737418;
	localparam logic [GAIN_W-1:0] KD_RST  = 32'd215;
	localparam logic [SI_W-1:0]   SI_RST  = 16'd3277;
	localparam logic [PPR_W-1:0]  PPR_RST = 16'd2343;

	typedef struct packed {
		logic [GAIN_W-1:0] kp_gain;
		logic [GAIN_W-1:0] ki_gain;
		logic [GAIN_W-1:0] kd_gain;
		logic [SI_W-1:0]   sample_interval;
		logic [PPR_W-1:0]  pulses_per_rev_x10;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_DEN_INIT,
		OP_DEN_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SPEED,
		OP_LOAD,
		OP_ERR,
		OP_MUL_SI,
		OP_INTEG,
		OP_ACC_KP,
		OP_ACC_KIL,
		OP_ACC_KIH,
		OP_ACC_KD,
		OP_DUTY
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEN,
		S_DIV_INIT,
		S_DIV,
		S_SPEED,
		S_ERR,
		S_MUL_SI,
		S_INTEG,
		S_ACC_KP,
		S_ACC_KIL,
		S_ACC_KIH,
		S_ACC_KD,
		S_DUTY
	} state_t;

endpackage

### rtl/encoder_speed_pid_loop.sv
// ----------------------------------------------------------------------------
// encoder_speed_pid_loop
// One motor channel: encoder period measurement turned into rpm, and a
// fixed-point PID step that produces a clamped PWM duty.
//
//   channel   direction  handshake             payload
//   item      in         item_valid/ready      mode, target_speed
//   result    out        result_valid/ready    duty, measured_speed
//   config    in         APB psel/penable      paddr, pwdata, prdata
//
// An encoder edge runs 16 shift-add steps for the denominator, then 38
// steps of the restoring divider. A control step uses the shared 32x32
// multiplier five times in sequence.
// Reset clears the state and loads the register defaults; no clearing pass.
// A control step waits in its last cycle while the result register is full.
// ----------------------------------------------------------------------------
module encoder_speed_pid_loop #(
	parameter int PERIOD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [espl_pkg::MODE_W-1:0]  mode,
	input  logic [espl_pkg::SPEED_W-1:0] target_speed,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [espl_pkg::DUTY_W-1:0]  duty,
	output logic [espl_pkg::SPEED_W-1:0] measured_speed,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [espl_pkg::ADDR_W-1:0]  paddr,
	input  logic [espl_pkg::DATA_W-1:0]  pwdata,
	output logic [espl_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import espl_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	espl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	espl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	espl_dp #(
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.target_speed   (target_speed),
		.duty           (duty),
		.measured_speed (measured_speed)
	);

endmodule

### rtl/espl_regs.sv
// ----------------------------------------------------------------------------
// espl_regs
// APB-style configuration registers: gains, sample interval and encoder
// pulses per revolution. Zero wait states.
// ----------------------------------------------------------------------------
module espl_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [espl_pkg::ADDR_W-1:0] paddr,
	input  logic [espl_pkg::DATA_W-1:0] pwdata,
	output logic [espl_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output espl_pkg::cfg_t              cfg
);
	import espl_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain            <= KP_RST;
			cfg_q.ki_gain            <= KI_RST;
			cfg_q.kd_gain            <= KD_RST;
			cfg_q.sample_interval    <= SI_RST;
			cfg_q.pulses_per_rev_x10 <= PPR_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_KP:  cfg_q.kp_gain            <= pwdata;
				REG_KI:  cfg_q.ki_gain            <= pwdata;
				REG_KD:  cfg_q.kd_gain            <= pwdata;
				REG_SI:  cfg_q.sample_interval    <= pwdata[SI_W-1:0];
				REG_PPR: cfg_q.pulses_per_rev_x10 <= pwdata[PPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP:  prdata = cfg_q.kp_gain;
			REG_KI:  prdata = cfg_q.ki_gain;
			REG_KD:  prdata = cfg_q.kd_gain;
			REG_SI:  prdata = DATA_W'(cfg_q.sample_interval);
			REG_PPR: prdata = DATA_W'(cfg_q.pulses_per_rev_x10);
			default: prdata = '0;
		endcase
	end

endmodule

### rtl/espl_ctrl.sv
// ----------------------------------------------------------------------------
// espl_ctrl
// Sequencer: accepts one transaction at a time, steps the datapath through
// the period multiply, the restoring divide or the PID step, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module espl_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [espl_pkg::MODE_W-1:0] mode,
	output logic                        result_valid,
	input  logic                        result_ready,
	output espl_pkg::cmd_t              cmd
);
	import espl_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             result_valid_q;
	logic             out_free;

	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == S_DUTY && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (mode)
						MODE_EDGE: state_d = S_DEN;
						MODE_STEP: state_d = S_ERR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_DEN: begin
				if (cnt_q == DEN_LAST) begin
					state_d = S_DIV_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = S_SPEED;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_SPEED:    state_d = S_IDLE;
			S_ERR:      state_d = S_MUL_SI;
			S_MUL_SI:   state_d = S_INTEG;
			S_INTEG:    state_d = S_ACC_KP;
			S_ACC_KP:   state_d = S_ACC_KIL;
			S_ACC_KIL:  state_d = S_ACC_KIH;
			S_ACC_KIH:  state_d = S_ACC_KD;
			S_ACC_KD:   state_d = S_DUTY;
			S_DUTY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		cmd.op     = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (mode)
						MODE_TICK: cmd.op = OP_TICK;
						MODE_EDGE: cmd.op = OP_DEN_INIT;
						MODE_STEP: cmd.op = OP_LOAD;
						default:   cmd.op = OP_NONE;
					endcase
				end
			end
			S_DEN:      cmd.op = OP_DEN_STEP;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV:      cmd.op = OP_DIV_STEP;
			S_SPEED:    cmd.op = OP_SPEED;
			S_ERR:      cmd.op = OP_ERR;
			S_MUL_SI:   cmd.op = OP_MUL_SI;
			S_INTEG:    cmd.op = OP_INTEG;
			S_ACC_KP:   cmd.op = OP_ACC_KP;
			S_ACC_KIL:  cmd.op = OP_ACC_KIL;
			S_ACC_KIH:  cmd.op = OP_ACC_KIH;
			S_ACC_KD:   cmd.op = OP_ACC_KD;
			S_DUTY:     cmd.op = out_free ? OP_DUTY : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

### rtl/espl_dp.sv
// ----------------------------------------------------------------------------
// espl_dp
// Datapath: period counter, shift-add denominator, restoring divider for the
// speed, one shared 32x32 multiplier for the PID terms, integral and
// accumulator, and the result registers.
// ----------------------------------------------------------------------------
module espl_dp #(
	parameter int PERIOD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  espl_pkg::cmd_t               cmd,
	input  espl_pkg::cfg_t               cfg,
	input  logic [espl_pkg::SPEED_W-1:0] target_speed,
	output logic [espl_pkg::DUTY_W-1:0]  duty,
	output logic [espl_pkg::SPEED_W-1:0] measured_speed
);
	import espl_pkg::*;

	localparam int DEN_W = PERIOD_WIDTH + PPR_W;
	localparam int CMP_W = (DEN_W > NUM_W) ? DEN_W : NUM_W;
	localparam int KI_W  = INTEG_W + GAIN_W;
	localparam int HI_W  = KI_W - GAIN_W;
	localparam logic [KI_W-1:0]            TERM_LIM  = KI_W'(1) << TERM_SHIFT;
	localparam logic signed [ACC_W-1:0]    FULL_Q40  = ACC_W'(1) << FULL_SHIFT;
	localparam logic signed [INTEG_W-1:0]  INTEG_HI  = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0]  INTEG_LO  = {1'b1, {(INTEG_W-1){1'b0}}};

	// architectural state
	logic [PERIOD_WIDTH-1:0]     period_q;
	logic [SPEED_W-1:0]          speed_q;
	logic signed [INTEG_W-1:0]   integ_q;
	logic signed [ERR_W-1:0]     prev_q;

	// working registers
	logic [DEN_W-1:0]            den_q;
	logic [DEN_W-1:0]            mcand_q;
	logic [PPR_W-1:0]            mplr_q;
	logic [NUM_W-1:0]            numer_q;
	logic [NUM_W-1:0]            rem_q;
	logic [NUM_W-1:0]            quo_q;
	logic [SPEED_W-1:0]          target_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [DIFF_W-1:0]    diff_q;
	logic [PROD_W-1:0]           prod_q;
	logic [PROD_W-1:0]           lo_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [DUTY_W-1:0]           duty_q;
	logic [SPEED_W-1:0]          meas_q;

	logic [NUM_W-1:0]            trial;
	logic                        ge;
	logic signed [ERR_W-1:0]     err_n;
	logic signed [DIFF_W-1:0]    diff_n;
	logic [ERR_W-1:0]            err_mag;
	logic [DIFF_W-1:0]           diff_mag;
	logic [INTEG_W-1:0]          int_mag;
	logic [GAIN_W-1:0]           mul_a;
	logic [GAIN_W-1:0]           mul_b;
	logic [PROD_W-1:0]           mul_p;
	logic signed [INTEG_W:0]     inc_p;
	logic signed [INTEG_W:0]     inc;
	logic signed [INTEG_W:0]     int_sum;
	logic signed [INTEG_W-1:0]   int_sat;
	logic [KI_W-1:0]             ki_w;
	logic [KI_W-1:0]             ki_sat;
	logic signed [ACC_W-1:0]     term;
	logic signed [ACC_W-1:0]     acc_add;
	logic [DUTY_W-1:0]           duty_n;

	assign duty           = duty_q;
	assign measured_speed = meas_q;

	// restoring divide step
	assign trial = {rem_q[NUM_W-2:0], numer_q[NUM_W-1]};
	assign ge    = CMP_W'(trial) >= CMP_W'(den_q);

	assign err_n  = $signed({1'b0, target_q}) - $signed({1'b0, speed_q});
	assign diff_n = $signed({err_n[ERR_W-1], err_n}) - $signed({prev_q[ERR_W-1], prev_q});

	assign err_mag  = err_q[ERR_W-1]    ? ERR_W'(-err_q)     : ERR_W'(err_q);
	assign diff_mag = diff_q[DIFF_W-1]  ? DIFF_W'(-diff_q)   : DIFF_W'(diff_q);
	assign int_mag  = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_MUL_SI: begin
				mul_a = GAIN_W'(cfg.sample_interval);
				mul_b = GAIN_W'(err_mag);
			end
			OP_INTEG: begin
				mul_a = cfg.kp_gain;
				mul_b = GAIN_W'(err_mag);
			end
			OP_ACC_KP: begin
				mul_a = cfg.ki_gain;
				mul_b = int_mag[GAIN_W-1:0];
			end
			OP_ACC_KIL: begin
				mul_a = cfg.ki_gain;
				mul_b = GAIN_W'(int_mag[INTEG_W-1:GAIN_W]);
			end
			OP_ACC_KIH: begin
				mul_a = cfg.kd_gain;
				mul_b = GAIN_W'(diff_mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// integral increment: floor(err * dt / 65536)
	always_comb begin
		inc_p = $signed({1'b0, prod_q[INTEG_W-1:0]});
		if (err_q[ERR_W-1]) begin
			inc_p = -inc_p;
		end
		inc     = inc_p >>> SI_W;
		int_sum = $signed({integ_q[INTEG_W-1], integ_q}) + inc;
		if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
			int_sat = int_sum[INTEG_W] ? INTEG_LO : INTEG_HI;
		end else begin
			int_sat = int_sum[INTEG_W-1:0];
		end
	end

	// integral term from two partial products, saturated at 2^60
	assign ki_w   = KI_W'(lo_q) + {prod_q[HI_W-1:0], {GAIN_W{1'b0}}};
	assign ki_sat = (ki_w > TERM_LIM) ? TERM_LIM : ki_w;

	always_comb begin
		case (cmd.op)
			OP_ACC_KIH: term = integ_q[INTEG_W-1] ? -$signed(ACC_W'(ki_sat))
			                                      : $signed(ACC_W'(ki_sat));
			OP_ACC_KD:  term = diff_q[DIFF_W-1] ? -$signed(ACC_W'(prod_q))
			                                    : $signed(ACC_W'(prod_q));
			default:    term = err_q[ERR_W-1] ? -$signed(ACC_W'(prod_q))
			                                  : $signed(ACC_W'(prod_q));
		endcase
		acc_add = acc_q + term;
	end

	always_comb begin
		if (acc_q <= 0) begin
			duty_n = '0;
		end else if (acc_q >= FULL_Q40) begin
			duty_n = DUTY_FULL;
		end else begin
			duty_n = acc_q[FULL_SHIFT:DUTY_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			speed_q  <= '0;
			integ_q  <= '0;
			prev_q   <= '0;
		end else begin
			case (cmd.op)
				OP_TICK: begin
					if (period_q != '1) begin
						period_q <= period_q + 1'b1;
					end
				end
				OP_SPEED: begin
					if (den_q == '0 || quo_q > NUM_W'(SPEED_MAX)) begin
						speed_q <= SPEED_MAX;
					end else begin
						speed_q <= quo_q[SPEED_W-1:0];
					end
					period_q <= '0;
				end
				OP_INTEG: begin
					integ_q <= int_sat;
					prev_q  <= err_q;
				end
				OP_DUTY:  speed_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DEN_INIT: begin
				den_q   <= '0;
				mcand_q <= DEN_W'(period_q);
				mplr_q  <= cfg.pulses_per_rev_x10;
			end
			OP_DEN_STEP: begin
				if (mplr_q[0]) begin
					den_q <= den_q + mcand_q;
				end
				mcand_q <= mcand_q << 1;
				mplr_q  <= mplr_q >> 1;
			end
			OP_DIV_INIT: begin
				rem_q   <= '0;
				quo_q   <= '0;
				numer_q <= SPEED_NUM;
			end
			OP_DIV_STEP: begin
				rem_q   <= ge ? (trial - NUM_W'(den_q)) : trial;
				quo_q   <= {quo_q[NUM_W-2:0], ge};
				numer_q <= numer_q << 1;
			end
			OP_LOAD: target_q <= target_speed;
			OP_ERR: begin
				err_q  <= err_n;
				diff_q <= diff_n;
			end
			OP_MUL_SI: prod_q <= mul_p;
			OP_INTEG:  prod_q <= mul_p;
			OP_ACC_KP: begin
				acc_q  <= term;
				prod_q <= mul_p;
			end
			OP_ACC_KIL: begin
				lo_q   <= prod_q;
				prod_q <= mul_p;
			end
			OP_ACC_KIH: begin
				acc_q  <= acc_add;
				prod_q <= mul_p;
			end
			OP_ACC_KD: acc_q <= acc_add;
			OP_DUTY: begin
				duty_q <= duty_n;
				meas_q <= speed_q;
			end
			default: ;
		endcase
	end

endmodule

### rtl/espl_chk.sv
// ----------------------------------------------------------------------------
// espl_chk
// Port-level checks for the encoder speed PID loop, bound to the top level.
// ----------------------------------------------------------------------------
module espl_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic [espl_pkg::MODE_W-1:0]  mode,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [espl_pkg::DUTY_W-1:0]  duty,
	input logic [espl_pkg::SPEED_W-1:0] measured_speed
);
	import espl_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(duty) && $stable(measured_speed))
		else $error("result changed while stalled");

	// duty never exceeds full on
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> duty <= DUTY_FULL)
		else $error("duty out of range");

	// a tick transaction leaves the block ready again in the next cycle
	a_tick_one: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && mode == MODE_TICK |=> item_ready)
		else $error("tick did not complete in one cycle");

	// a control step keeps the block busy and cannot produce a result at once
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && mode == MODE_STEP |=>
			!item_ready && !$rose(result_valid))
		else $error("control step finished too early");

	// no result right out of reset
	a_reset_clean: assert property (@(posedge clk)
		!$past(arst_n) |-> !result_valid)
		else $error("result valid after reset");

endmodule

bind encoder_speed_pid_loop espl_chk u_chk (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for encoder_speed_pid_loop. Tick, encoder edge and
// control step transactions are sent in bursts with random gaps while the
// result side stalls in windows. An in-bench model of the period counter,
// the speed divide and the PID step predicts each duty and speed. The APB
// port moves the gains and encoder settings through several settings, with
// read-back. The block is built with a 16-bit period counter.
// ----------------------------------------------------------------------------
module testbench;
	import espl_pkg::*;

	localparam int PERIOD_W    = 16;
	localparam int CYCLE_CAP   = 4000000;
	localparam int SETTLE      = 80;
	localparam int PHASE_ITEMS = 165;
	localparam int PHASE_STEPS = 6;
	localparam longint INTEG_HI = (longint'(1) << 40) - 1;
	localparam longint INTEG_LO = -(longint'(1) << 40);
	localparam longint DUTY_ONE = longint'(1) << FULL_SHIFT;
	localparam logic [72:0] TERM_CAP = 73'(1) << TERM_SHIFT;
	localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SPEED_W-1:0] target;
	} motor_cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic [SPEED_W-1:0] speed;
	} duty_rec_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	logic [MODE_W-1:0]   mode = MODE_TICK;
	logic [SPEED_W-1:0]  target_speed = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [DUTY_W-1:0]   duty;
	logic [SPEED_W-1:0]  measured_speed;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// model of the channel
	cfg_t                cfg_mdl;
	logic [PERIOD_W-1:0] period_mdl;
	logic [SPEED_W-1:0]  speed_mdl;
	longint              integ_mdl;
	longint              prev_err_mdl;

	motor_cmd_t cmd_backlog[$];
	duty_rec_t  duty_expected[$];
	motor_cmd_t next_cmd;
	motor_cmd_t seen_cmd;
	duty_rec_t  want;

	int issued = 0;
	int accepted = 0;
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_left = 0;

	encoder_speed_pid_loop #(
		.PERIOD_WIDTH(PERIOD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.target_speed(target_speed),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.duty(duty),
		.measured_speed(measured_speed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// unsigned gain times signed value, magnitude capped at 2^60
	function automatic longint gain_term(logic [GAIN_W-1:0] g, longint v);
		logic [INTEG_W-1:0] mag;
		logic [72:0]        p;
		mag = (v < 0) ? INTEG_W'(-v) : INTEG_W'(v);
		p = 73'(g) * 73'(mag);
		if (p > TERM_CAP)
			p = TERM_CAP;
		return (v < 0) ? -longint'(p[62:0]) : longint'(p[62:0]);
	endfunction

	function automatic logic [DATA_W-1:0] cfg_readback(logic [IDX_W-1:0] idx);
		case (idx)
			REG_KP:  return cfg_mdl.kp_gain;
			REG_KI:  return cfg_mdl.ki_gain;
			REG_KD:  return cfg_mdl.kd_gain;
			REG_SI:  return DATA_W'(cfg_mdl.sample_interval);
			REG_PPR: return DATA_W'(cfg_mdl.pulses_per_rev_x10);
			default: return '0;
		endcase
	endfunction

	task automatic write_cfg_model(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
		case (idx)
			REG_KP:  cfg_mdl.kp_gain = d;
			REG_KI:  cfg_mdl.ki_gain = d;
			REG_KD:  cfg_mdl.kd_gain = d;
			REG_SI:  cfg_mdl.sample_interval = d[SI_W-1:0];
			REG_PPR: cfg_mdl.pulses_per_rev_x10 = d[PPR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cmd(motor_cmd_t c);
		logic [47:0] den;
		logic [63:0] q;
		longint      err;
		longint      sum;
		duty_rec_t   r;
		case (c.mode)
			MODE_TICK: begin
				if (period_mdl != '1)
					period_mdl = period_mdl + 1'b1;
			end
			MODE_EDGE: begin
				den = 48'(cfg_mdl.pulses_per_rev_x10) * 48'(period_mdl);
				q = (den == '0) ? 64'(SPEED_MAX) : 64'(SPEED_NUM) / 64'(den);
				speed_mdl = (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[SPEED_W-1:0];
				period_mdl = '0;
			end
			MODE_STEP: begin
				err = longint'(c.target) - longint'(speed_mdl);
				// arithmetic shift gives the floor for negative errors
				integ_mdl = integ_mdl + ((err * longint'(cfg_mdl.sample_interval)) >>> 16);
				if (integ_mdl > INTEG_HI)
					integ_mdl = INTEG_HI;
				if (integ_mdl < INTEG_LO)
					integ_mdl = INTEG_LO;
				sum = gain_term(cfg_mdl.kp_gain, err) + gain_term(cfg_mdl.ki_gain, integ_mdl)
					+ gain_term(cfg_mdl.kd_gain, err - prev_err_mdl);
				prev_err_mdl = err;
				if (sum <= 0)
					r.duty = '0;
				else if (sum >= DUTY_ONE)
					r.duty = DUTY_FULL;
				else
					r.duty = DUTY_W'(sum >>> DUTY_SHIFT);
				r.speed = speed_mdl;
				duty_expected.push_back(r);
				speed_mdl = '0;
			end
			default: ;
		endcase
	endtask

	task automatic reset_model();
		cfg_mdl.kp_gain = KP_RST;
		cfg_mdl.ki_gain = KI_RST;
		cfg_mdl.kd_gain = KD_RST;
		cfg_mdl.sample_interval = SI_RST;
		cfg_mdl.pulses_per_rev_x10 = PPR_RST;
		period_mdl = '0;
		speed_mdl = '0;
		integ_mdl = 0;
		prev_err_mdl = 0;
	endtask

	task automatic push_cmd(logic [MODE_W-1:0] m, logic [SPEED_W-1:0] t);
		cmd_backlog.push_back({m, t});
		issued++;
	endtask

	function automatic logic [SPEED_W-1:0] rand_target();
		int k;
		k = $urandom_range(0, 7);
		case (k)
			0:       return '0;
			1:       return SPEED_MAX;
			2, 3, 4: return SPEED_W'($urandom_range(0, 24'hFFFFFF));
			default: return SPEED_W'($urandom_range(0, 24'h1FFFFF));
		endcase
	endfunction

	task automatic apb_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(logic [IDX_W-1:0] idx);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== cfg_readback(idx)) begin
			$error("prdata: expected %0h, got %0h (register %0d)", cfg_readback(idx),
				prdata, idx);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_all_regs();
		for (int i = 0; i <= int'(REG_PPR); i++)
			apb_read(IDX_W'(i));
	endtask

	// everything sent, every result back, and the edge divider given time to finish
	task automatic wait_idle();
		while (accepted != issued || duty_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly tick runs closed by an edge and a step, with some broken sequences
	task automatic random_phase();
		int items;
		int steps;
		int ticks;
		int k;
		items = 0;
		steps = 0;
		while (items < PHASE_ITEMS || steps < PHASE_STEPS) begin
			k = $urandom_range(0, 19);
			if (k < 5)
				ticks = $urandom_range(0, 3);
			else if (k < 19)
				ticks = $urandom_range(4, 24);
			else
				ticks = $urandom_range(80, 400);
			repeat (ticks) push_cmd(MODE_TICK, rand_target());
			items += ticks;
			if ($urandom_range(0, 99) < 85) begin
				push_cmd(MODE_EDGE, rand_target());
				items++;
				if ($urandom_range(0, 19) == 0) begin
					push_cmd(MODE_EDGE, rand_target());
					items++;
				end
			end
			if ($urandom_range(0, 11) == 0)
				push_cmd(MODE_SPARE, rand_target());
			if ($urandom_range(0, 9) != 0) begin
				push_cmd(MODE_STEP, rand_target());
				items++;
				steps++;
				if ($urandom_range(0, 7) == 0) begin
					push_cmd(MODE_STEP, rand_target());
					items++;
					steps++;
				end
			end
		end
	endtask

	// sender: bursts of back-to-back transactions separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				next_cmd = cmd_backlog.pop_front();
				mode <= next_cmd.mode;
				target_speed <= next_cmd.target;
				item_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 31);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: free-flowing windows alternate with choppy ones
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (cycles[8] && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 11);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				seen_cmd = {mode, target_speed};
				apply_cmd(seen_cmd);
				accepted++;
			end
			if (psel && penable && pwrite && pready)
				write_cfg_model(paddr[ADDR_W-1:2], pwdata);
			if (result_valid && result_ready) begin
				if (duty_expected.size() == 0) begin
					$error("unexpected result transaction: duty %0d, measured_speed %0d",
						duty, measured_speed);
					errors++;
				end else begin
					want = duty_expected.pop_front();
					if (duty !== want.duty) begin
						$error("duty: expected %0d, got %0d", want.duty, duty);
						errors++;
					end
					if (measured_speed !== want.speed) begin
						$error("measured_speed: expected %0d, got %0d", want.speed,
							measured_speed);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		read_all_regs();

		// reset settings: zero period, oversize quotient, ignored mode, bit patterns
		push_cmd(MODE_STEP, '0);
		push_cmd(MODE_STEP, SPEED_MAX);
		push_cmd(MODE_EDGE, '0);
		push_cmd(MODE_STEP, '0);
		repeat (3) push_cmd(MODE_TICK, 24'h555555);
		push_cmd(MODE_EDGE, 24'hAAAAAA);
		push_cmd(MODE_STEP, 24'h555555);
		push_cmd(MODE_SPARE, 24'hAAAAAA);
		repeat (12) push_cmd(MODE_TICK, SPEED_MAX);
		push_cmd(MODE_EDGE, '0);
		push_cmd(MODE_STEP, 24'hAAAAAA);
		push_cmd(MODE_STEP, 24'h123456);
		push_cmd(MODE_EDGE, '0);
		push_cmd(MODE_STEP, 24'h000400);
		random_phase();
		wait_idle();

		// all at the top of their range
		apb_write(REG_KP, '1);
		apb_write(REG_KI, '1);
		apb_write(REG_KD, '1);
		apb_write(REG_SI, '1);
		apb_write(REG_PPR, '1);
		read_all_regs();
		repeat (2) push_cmd(MODE_TICK, '0);
		push_cmd(MODE_EDGE, '0);
		push_cmd(MODE_STEP, SPEED_MAX);
		push_cmd(MODE_STEP, '0);
		random_phase();
		wait_idle();

		// all zero, including the pulse count; writes above the map are dropped
		apb_write(REG_KP, '0);
		apb_write(REG_KI, '0);
		apb_write(REG_KD, '0);
		apb_write(REG_SI, '0);
		apb_write(REG_PPR, '0);
		apb_write(REG_UNUSED_LO, $urandom);
		apb_write(REG_UNUSED_HI, $urandom);
		read_all_regs();
		repeat (5) push_cmd(MODE_TICK, '0);
		push_cmd(MODE_EDGE, '0);
		push_cmd(MODE_STEP, SPEED_MAX);
		random_phase();
		wait_idle();

		// gains in a range where the duty moves
		apb_write(REG_KP, $urandom_range(0, 32'h0800_0000));
		apb_write(REG_KI, $urandom_range(0, 32'h0800_0000));
		apb_write(REG_KD, $urandom);
		apb_write(REG_SI, $urandom_range(0, 16'hFFFF));
		apb_write(REG_PPR, $urandom_range(1, 16'hFFFF));
		read_all_regs();
		random_phase();
		wait_idle();

		// pulse count register at one (0.1 pulse per revolution), random gains
		apb_write(REG_KP, $urandom);
		apb_write(REG_KI, $urandom);
		apb_write(REG_KD, $urandom_range(0, 32'h00FF_FFFF));
		apb_write(REG_SI, $urandom_range(0, 16'hFFFF));
		apb_write(REG_PPR, 32'd1);
		read_all_regs();
		random_phase();
		wait_idle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
rtl/espl_pkg.sv
rtl/espl_regs.sv
rtl/espl_ctrl.sv
rtl/espl_dp.sv
rtl/encoder_speed_pid_loop.sv
rtl/espl_chk.sv
test/testbench.sv
